/* hw/rtl/lbps_pkg.sv */
// Package for the LED blink pattern sequencer: pattern codes, register and
// function codes, and the fixed pattern tables. No dependencies.
package lbps_pkg;

  typedef enum logic [1:0] {
    PAT_SLOW   = 2'd0,
    PAT_FAST   = 2'd1,
    PAT_STROBE = 2'd2,
    PAT_CUSTOM = 2'd3
  } pattern_e;

  // configuration register indexes
  localparam logic REG_PATTERN = 1'b0;
  localparam logic REG_LENGTH  = 1'b1;

  // input item function codes
  localparam logic FUNC_PLAY  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam logic [15:0] SLOW_MS       = 16'd700;
  localparam logic [15:0] FAST_MS       = 16'd300;
  localparam logic [15:0] STROBE_MS     = 16'd70;
  localparam logic [15:0] STROBE_GAP_MS = 16'd500;

  localparam logic [4:0] BLINK_LEN  = 5'd4;
  localparam logic [4:0] STROBE_LEN = 5'd12;

  // length of a fixed pattern
  function automatic logic [4:0] fixed_length(pattern_e pat);
    logic [4:0] len;
    unique case (pat)
      PAT_SLOW, PAT_FAST: len = BLINK_LEN;
      PAT_STROBE:         len = STROBE_LEN;
      default:            len = 5'd0;
    endcase
    return len;
  endfunction

  // entry of a fixed pattern; even positions are levels, odd ones delays
  function automatic logic [15:0] fixed_entry(pattern_e pat, logic [4:0] pos);
    logic [15:0] val;
    val = 16'd0;
    unique case (pat)
      PAT_SLOW: begin
        if (pos < BLINK_LEN) val = pos[0] ? SLOW_MS : {15'd0, (pos == 5'd0)};
      end
      PAT_FAST: begin
        if (pos < BLINK_LEN) val = pos[0] ? FAST_MS : {15'd0, (pos == 5'd0)};
      end
      PAT_STROBE: begin
        if (pos < STROBE_LEN) begin
          if (pos[0]) val = (pos == STROBE_LEN - 5'd1) ? STROBE_GAP_MS : STROBE_MS;
          else        val = {15'd0, (pos[1] == 1'b0)};
        end
      end
      default: val = 16'd0;
    endcase
    return val;
  endfunction

endpackage

/* hw/rtl/lbps_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Read before write on a shared address. No dependencies.
module lbps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/led_blink_pattern_sequencer_top.sv */
// LED blink pattern sequencer top level: play state, custom table in RAM,
// output register. Uses lbps_pkg and lbps_ram.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------------
//   in       | in_valid_i/in_ready_o| func_i ms_tick_i entry_index_i entry_value_i
//   out      | out_valid_o/out_ready_i | led_on_o step_position_o delay_running_o
//   cfg      | cfg_we_i (no wait)   | cfg_index_i cfg_data_i
//
// One item per clock while the output is not stalled; its result beat shows in the cycle after acceptance.
// The custom table read is prefetched: the RAM always reads the entry at the
// next position, so its read latency is hidden; a table write to that
// entry in the same cycle is forwarded.
// Reset takes effect at once: per-entry valid bits make unwritten entries read
// as zero, no clearing pass.
// in_ready_o is high while the output register is empty or being drained.
module led_blink_pattern_sequencer_top #(
  parameter int CUSTOM_DEPTH = 16,
  parameter int DELAY_WIDTH  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic        ms_tick_i,
  input  logic [3:0]  entry_index_i,
  input  logic [15:0] entry_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        led_on_o,
  output logic [4:0]  step_position_o,
  output logic        delay_running_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [4:0]  cfg_data_i
);

  localparam int AW = $clog2(CUSTOM_DEPTH);

  lbps_pkg::pattern_e     pattern_q;
  logic [4:0]             cust_len_q;
  logic [4:0]             pos_q, pos_d;
  logic [DELAY_WIDTH-1:0] rem_q, rem_d;
  logic                   led_q, led_d;
  logic [CUSTOM_DEPTH-1:0] valid_q;

  logic                   out_valid_q;
  logic                   out_led_q;
  logic [4:0]             out_pos_q;
  logic                   out_run_q;

  logic                   in_acc;
  logic                   play;
  logic                   tbl_we;
  logic [AW-1:0]          waddr;
  logic [AW-1:0]          raddr;
  logic [15:0]            rdata;
  logic                   fwd_hit_q;
  logic [15:0]            fwd_data_q;
  logic                   ent_vld_q;

  logic [4:0]             len;
  logic [15:0]            entry;
  logic [15:0]            cust_entry;
  logic [DELAY_WIDTH-1:0] rem_tick;
  logic [31:0]            entry_ext;
  logic [31:0]            widx_ext;
  logic [31:0]            pos_ext;
  logic [31:0]            cl_ext;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign play       = in_acc && (func_i == lbps_pkg::FUNC_PLAY);

  assign widx_ext = {28'd0, entry_index_i};
  assign tbl_we   = in_acc && (func_i == lbps_pkg::FUNC_WRITE) && (widx_ext < CUSTOM_DEPTH);
  assign waddr    = widx_ext[AW-1:0];

  // active length, custom length saturated to the table depth
  assign cl_ext = {27'd0, cust_len_q};
  always_comb begin
    if (pattern_q == lbps_pkg::PAT_CUSTOM) begin
      len = (cl_ext > CUSTOM_DEPTH) ? 5'(CUSTOM_DEPTH) : cust_len_q;
    end else begin
      len = lbps_pkg::fixed_length(pattern_q);
    end
  end

  // entry at pos_q: RAM output holds table[pos_q] thanks to the prefetch
  assign cust_entry = fwd_hit_q ? fwd_data_q : (ent_vld_q ? rdata : 16'd0);
  assign entry = (pattern_q == lbps_pkg::PAT_CUSTOM) ? cust_entry
                                                     : lbps_pkg::fixed_entry(pattern_q, pos_q);
  assign entry_ext = {16'd0, entry};

  always_comb begin
    rem_tick = rem_q;
    if (ms_tick_i && (rem_q != '0)) rem_tick = rem_q - DELAY_WIDTH'(1);
    pos_d = pos_q;
    rem_d = rem_q;
    led_d = led_q;
    if (play) begin
      rem_d = rem_tick;
      if (pos_q < len) begin
        if (rem_tick == '0) begin
          if (!pos_q[0]) led_d = (entry != 16'd0);
          else           rem_d = entry_ext[DELAY_WIDTH-1:0];
          pos_d = pos_q + 5'd1;
        end
      end else begin
        pos_d = 5'd0;
      end
    end
    if (cfg_we_i && (cfg_index_i == lbps_pkg::REG_PATTERN)) rem_d = '0;
  end

  assign pos_ext = {27'd0, pos_d};
  assign raddr   = pos_ext[AW-1:0];

  lbps_ram #(
    .WIDTH(16),
    .DEPTH(CUSTOM_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(waddr),
    .wdata_i(entry_value_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q   <= lbps_pkg::PAT_SLOW;
      cust_len_q  <= 5'd0;
      pos_q       <= 5'd0;
      rem_q       <= '0;
      led_q       <= 1'b0;
      valid_q     <= '0;
      fwd_hit_q   <= 1'b0;
      ent_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      rem_q <= rem_d;
      led_q <= led_d;
      if (cfg_we_i) begin
        if (cfg_index_i == lbps_pkg::REG_PATTERN) begin
          pattern_q <= lbps_pkg::pattern_e'(cfg_data_i[1:0]);
        end else begin
          cust_len_q <= cfg_data_i;
        end
      end
      if (tbl_we) valid_q[waddr] <= 1'b1;
      // RAM reads old data on a same-address write; forward the new value
      fwd_hit_q <= tbl_we && (waddr == raddr);
      ent_vld_q <= valid_q[raddr];
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= entry_value_i;
    if (in_acc) begin
      out_led_q <= led_d;
      out_pos_q <= pos_d;
      out_run_q <= (rem_d != '0);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign led_on_o        = out_led_q;
  assign step_position_o = out_pos_q;
  assign delay_running_o = out_run_q;

endmodule

/* hw/rtl/lbps_checker.sv */
// Port-level checks for the LED blink pattern sequencer, bound to the top.
// Depends on led_blink_pattern_sequencer_top port names.
module lbps_checker #(
  parameter int CUSTOM_DEPTH = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       led_on_o,
  input logic [4:0] step_position_o,
  input logic       delay_running_o
);

  localparam int CustMax = (CUSTOM_DEPTH < 31) ? CUSTOM_DEPTH : 31;
  localparam int MaxPos  = (CustMax > 12) ? CustMax : 12;

  // every accepted beat shows its result on the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> out_valid_o)
    else $error("accepted beat gave no result");

  // input is taken only when the output register can hold the new result
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!out_valid_o || out_ready_i))
    else $error("input ready while result stalled");

  // position never passes the longest possible pattern
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({27'd0, step_position_o} <= MaxPos))
    else $error("position beyond pattern length");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(led_on_o) && $stable(step_position_o)
       && $stable(delay_running_o)))
    else $error("stalled result beat changed");

endmodule

bind led_blink_pattern_sequencer_top lbps_checker #(
  .CUSTOM_DEPTH(CUSTOM_DEPTH)
) u_lbps_checker (.*);
